// ===== design/rfr_pkg.sv =====
`timescale 1ns / 1ps

package rfr_pkg;

  localparam int ByteW          = 8;
  localparam int DistW          = 13;
  localparam int RawW           = 16;
  localparam int NumRangeFields = 8;

  // reciprocal of ten, exact for any 16-bit raw value
  localparam int RecipW     = 17;
  localparam int RecipShift = 19;
  localparam logic [RecipW-1:0] RecipTen = 17'd52429;
  localparam logic [DistW-1:0]  DistOffset = 13'd10;

  localparam logic CfgSyncFirst  = 1'b0;
  localparam logic CfgSyncSecond = 1'b1;

  typedef struct packed {
    logic emit;
    logic start;
  } seq_stat_t;

  function automatic logic [DistW-1:0] scale_distance(input logic [RawW-1:0] raw);
    logic [RawW+RecipW-1:0] prod;
    logic [DistW-1:0]       q;
    prod = {{RecipW{1'b0}}, raw} * {{RawW{1'b0}}, RecipTen};
    q    = prod[RecipShift+DistW-1:RecipShift];
    return (q < DistOffset) ? '0 : (q - DistOffset);
  endfunction

endpackage

// ===== design/rfr_cell.sv =====
`timescale 1ns / 1ps

module rfr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [rfr_pkg::ByteW-1:0] din,
  output logic [rfr_pkg::ByteW-1:0] dout
);

  logic [rfr_pkg::ByteW-1:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

// ===== design/rfr_seq.sv =====
`timescale 1ns / 1ps

module rfr_seq #(
  parameter int RANGE_SLOTS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [rfr_pkg::ByteW-1:0] rx_byte,
  input  logic [rfr_pkg::ByteW-1:0] prev_byte,
  input  logic [rfr_pkg::ByteW-1:0] sync_first,
  input  logic [rfr_pkg::ByteW-1:0] sync_second,
  output rfr_pkg::seq_stat_t        stat
);

  localparam int PosW = $clog2(RANGE_SLOTS + 3);
  localparam logic [PosW-1:0] PosIdle = '0;
  localparam logic [PosW-1:0] PosHigh = PosW'(RANGE_SLOTS + 1);
  localparam logic [PosW-1:0] PosLow  = PosW'(RANGE_SLOTS + 2);

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;

  always_comb begin
    stat.start = (rx_byte == sync_second) && (prev_byte == sync_first);
    stat.emit  = accept && (pos == PosLow);
    if (pos != PosIdle && pos <= PosHigh) begin
      pos_next = pos + PosW'(1);
    end else begin
      pos_next = PosIdle;
    end
    if (stat.start) begin
      pos_next = PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= PosIdle;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= PosLow)
    else $error("frame position out of range");

  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    accept && stat.start |=> pos == PosW'(1))
    else $error("sync did not restart frame");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    stat.emit && !stat.start |=> pos == PosIdle)
    else $error("no return to idle after frame end");

endmodule

// ===== design/range_frame_receiver.sv =====
`timescale 1ns / 1ps

// Range frame receiver.
// rx_byte arrives on in_valid/in_ready, one byte per beat. Two bytes equal to
// sync_first then sync_second open a frame (or restart one in progress); the
// next RANGE_SLOTS bytes are range slots, then the high and low bytes of a raw
// 16-bit distance. When the low byte is taken, one result beat goes out on
// out_valid/out_ready: eight ranges (slots beyond RANGE_SLOTS read 0) and
// distance = raw/10 - 10, clamped at 0.
// The result is registered and valid the cycle after the low byte is accepted.
// One byte per cycle while in_ready is high; bytes shift through a row of
// RANGE_SLOTS+1 byte cells, and the output register holds one finished result.
// in_ready drops only while a result is held and out_ready is low.
// Sync registers are written via cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block does not enforce it. Reset clears
// the frame position, the previous byte, the sync registers and out_valid.

module range_frame_receiver #(
  parameter int RANGE_SLOTS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rfr_pkg::ByteW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rfr_pkg::ByteW-1:0] rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rfr_pkg::ByteW-1:0] range_front,
  output logic [rfr_pkg::ByteW-1:0] range_rear,
  output logic [rfr_pkg::ByteW-1:0] range_askew_right,
  output logic [rfr_pkg::ByteW-1:0] range_askew_left,
  output logic [rfr_pkg::ByteW-1:0] range_rear_right,
  output logic [rfr_pkg::ByteW-1:0] range_rear_left,
  output logic [rfr_pkg::ByteW-1:0] range_right,
  output logic [rfr_pkg::ByteW-1:0] range_left,
  output logic [rfr_pkg::DistW-1:0] distance
);

  logic [rfr_pkg::ByteW-1:0] sync_first;
  logic [rfr_pkg::ByteW-1:0] sync_second;
  logic                      accept;
  rfr_pkg::seq_stat_t        stat;

  // chain[0] is the last byte taken; at frame end chain[RANGE_SLOTS-j] is slot j
  logic [rfr_pkg::ByteW-1:0] chain [RANGE_SLOTS+1];
  logic [rfr_pkg::ByteW-1:0] rng_sel [rfr_pkg::NumRangeFields];
  logic [rfr_pkg::ByteW-1:0] rng_out [rfr_pkg::NumRangeFields];
  logic [rfr_pkg::DistW-1:0] dist_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= '0;
      sync_second <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfr_pkg::CfgSyncFirst:  sync_first  <= cfg_data;
        rfr_pkg::CfgSyncSecond: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  generate
    for (genvar k = 0; k <= RANGE_SLOTS; k++) begin : g_cell
      if (k == 0) begin : g_head
        rfr_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (accept),
          .din   (rx_byte),
          .dout  (chain[k])
        );
      end else begin : g_body
        rfr_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (accept),
          .din   (chain[k-1]),
          .dout  (chain[k])
        );
      end
    end

    for (genvar j = 0; j < rfr_pkg::NumRangeFields; j++) begin : g_rng
      if (j < RANGE_SLOTS) begin : g_used
        assign rng_sel[j] = chain[RANGE_SLOTS-j];
      end else begin : g_empty
        assign rng_sel[j] = '0;
      end
    end
  endgenerate

  rfr_seq #(
    .RANGE_SLOTS (RANGE_SLOTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .prev_byte   (chain[0]),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .stat        (stat)
  );

  assign dist_next = rfr_pkg::scale_distance({chain[0], rx_byte});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      rng_out  <= rng_sel;
      distance <= dist_next;
    end
  end

  assign range_front       = rng_out[0];
  assign range_rear        = rng_out[1];
  assign range_askew_right = rng_out[2];
  assign range_askew_left  = rng_out[3];
  assign range_rear_right  = rng_out[4];
  assign range_rear_left   = rng_out[5];
  assign range_right       = rng_out[6];
  assign range_left        = rng_out[7];

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    stat.emit |=> out_valid)
    else $error("frame end did not raise out_valid");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !stat.emit |=> !out_valid)
    else $error("result beat repeated");

  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance <= 13'd6543)
    else $error("distance above maximum");

  a_chain_shift: assert property (@(posedge clk) disable iff (rst)
    accept |=> chain[0] == $past(rx_byte))
    else $error("byte chain did not shift");

endmodule
